// ----- src/hmsu_pkg.sv -----
package hmsu_pkg;

  localparam int IDX_W = 8;

  localparam logic [2:0] REG_COUPLING_X = 3'd0;
  localparam logic [2:0] REG_COUPLING_Y = 3'd1;
  localparam logic [2:0] REG_COUPLING_Z = 3'd2;
  localparam logic [2:0] REG_FIELD      = 3'd3;
  localparam logic [2:0] REG_STEP       = 3'd4;
  localparam logic [2:0] REG_ACC_SCALE  = 3'd5;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
    logic signed [15:0] comp_z;
    logic [15:0]        uniform_draw;
  } req_t;

  typedef struct packed {
    logic [47:0] j_x;
    logic [47:0] j_y;
    logic [47:0] j_z;
    logic [47:0] field;
    logic [15:0] step;
    logic [23:0] acc_scale;
  } cfg_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] energy_delta;
    logic signed [39:0] total_energy;
    logic [31:0]        accept_count;
  } res_t;

endpackage

// ----- src/heisenberg_metropolis_site_update.sv -----
// load request: the spin is written as the request is taken from the queue, one at a time
// update request: runs the shared 25x36 multiplier sequence, the 32-step bit-serial
// square root, one divider used once per component and the exp chain; the exp chain
// is skipped when the energy change is not positive
// a two-entry request queue takes new requests while an update is in progress
// synchronous active-high reset clears control, running energy and accept count
// spin store holds no reset value; a site must be loaded before it is read
module heisenberg_metropolis_site_update #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic signed [15:0] comp_x,
  input  logic signed [15:0] comp_y,
  input  logic signed [15:0] comp_z,
  input  logic [15:0]        uniform_draw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               accepted,
  output logic signed [31:0] energy_delta,
  output logic signed [39:0] total_energy,
  output logic [31:0]        accept_count
);
  import hmsu_pkg::*;

  cfg_t       cfg;
  req_t       req;
  res_t       res;
  logic       req_valid;
  logic       req_pop;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.j_x       <= '0;
      cfg.j_y       <= '0;
      cfg.j_z       <= '0;
      cfg.field     <= '0;
      cfg.step      <= 16'd32768;
      cfg.acc_scale <= 24'd83886;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_COUPLING_X: cfg.j_x       <= pwdata[47:0];
        REG_COUPLING_Y: cfg.j_y       <= pwdata[47:0];
        REG_COUPLING_Z: cfg.j_z       <= pwdata[47:0];
        REG_FIELD:      cfg.field     <= pwdata[47:0];
        REG_STEP:       cfg.step      <= pwdata[15:0];
        REG_ACC_SCALE:  cfg.acc_scale <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COUPLING_X: prdata = {16'd0, cfg.j_x};
      REG_COUPLING_Y: prdata = {16'd0, cfg.j_y};
      REG_COUPLING_Z: prdata = {16'd0, cfg.j_z};
      REG_FIELD:      prdata = {16'd0, cfg.field};
      REG_STEP:       prdata = {48'd0, cfg.step};
      REG_ACC_SCALE:  prdata = {40'd0, cfg.acc_scale};
      default:        prdata = '0;
    endcase
  end

  hmsu_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .row          (row),
    .col          (col),
    .comp_x       (comp_x),
    .comp_y       (comp_y),
    .comp_z       (comp_z),
    .uniform_draw (uniform_draw),
    .req_valid    (req_valid),
    .req          (req),
    .req_pop      (req_pop)
  );

  hmsu_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign accepted     = res.accepted;
  assign energy_delta = res.energy_delta;
  assign total_energy = res.total_energy;
  assign accept_count = res.accept_count;

endmodule

// ----- src/hmsu_front.sv -----
module hmsu_front #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [3:0]         row,
  input  logic [3:0]         col,
  input  logic signed [15:0] comp_x,
  input  logic signed [15:0] comp_y,
  input  logic signed [15:0] comp_z,
  input  logic [15:0]        uniform_draw,
  output logic               req_valid,
  output hmsu_pkg::req_t     req,
  input  logic               req_pop
);
  import hmsu_pkg::*;

  localparam logic [IDX_W:0] ROWS_V = (IDX_W+1)'(ROWS);
  localparam logic [IDX_W:0] COLS_V = (IDX_W+1)'(COLS);

  req_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  logic [IDX_W:0] rr;
  logic [IDX_W:0] cc;
  req_t       item;

  // wrap the site onto the lattice
  always_comb begin
    rr = (IDX_W+1)'(row);
    cc = (IDX_W+1)'(col);
    for (int i = 0; i < 6; i++) begin
      if (rr >= ROWS_V) rr = rr - ROWS_V;
      if (cc >= COLS_V) cc = cc - COLS_V;
    end
    item.op           = op;
    item.row          = rr[IDX_W-1:0];
    item.col          = cc[IDX_W-1:0];
    item.comp_x       = comp_x;
    item.comp_y       = comp_y;
    item.comp_z       = comp_z;
    item.uniform_draw = uniform_draw;
  end

  assign in_ready  = (cnt != 2'd2);
  assign req_valid = (cnt != 2'd0);
  assign req       = q[rp];
  assign push      = in_valid && in_ready;
  assign pop       = req_pop && req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= item;
  end

endmodule

// ----- src/hmsu_back.sv -----
module hmsu_back #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  hmsu_pkg::cfg_t cfg,
  input  logic           req_valid,
  input  hmsu_pkg::req_t req,
  output logic           req_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output hmsu_pkg::res_t res
);
  import hmsu_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_PROP, S_SQR, S_CHECK, S_ROOT, S_DIV, S_GSUM,
    S_DSUM, S_ROUND, S_SCALE, S_EXP, S_JUDGE, S_COMMIT, S_DONE
  } state_t;

  function automatic logic signed [15:0] lane(input logic [47:0] v, input logic [1:0] i);
    logic signed [15:0] r;
    case (i)
      2'd0:    r = v[15:0];
      2'd1:    r = v[31:16];
      default: r = v[47:32];
    endcase
    return r;
  endfunction

  // exp(-2^(i-16)) in Q0.30
  function automatic logic [29:0] exp_tab(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd1073725440;
      5'd1:    r = 30'd1073709056;
      5'd2:    r = 30'd1073676290;
      5'd3:    r = 30'd1073610760;
      5'd4:    r = 30'd1073479712;
      5'd5:    r = 30'd1073217664;
      5'd6:    r = 30'd1072693760;
      5'd7:    r = 30'd1071646719;
      5'd8:    r = 30'd1069555701;
      5'd9:    r = 30'd1065385899;
      5'd10:   r = 30'd1057095000;
      5'd11:   r = 30'd1040706261;
      5'd12:   r = 30'd1008687096;
      5'd13:   r = 30'd947573834;
      5'd14:   r = 30'd836230973;
      5'd15:   r = 30'd651257337;
      5'd16:   r = 30'd395007542;
      5'd17:   r = 30'd145315154;
      5'd18:   r = 30'd19666268;
      5'd19:   r = 30'd360200;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r * COLS + c);
  endfunction

  state_t state;
  req_t   cur;
  logic [RW-1:0] r_i;
  logic [CW-1:0] c_i;

  logic [47:0] mem [DEPTH];
  logic [AW-1:0] raddr;
  logic [47:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [47:0]   wdata;

  logic [2:0] cnt;
  logic [1:0] k;
  logic [2:0] m;
  logic       ph;

  logic signed [15:0] s     [3];
  logic signed [16:0] a_sum [3];
  logic signed [16:0] b_sum [3];
  logic signed [17:0] p     [3];
  logic signed [15:0] nw    [3];
  logic signed [35:0] g     [3];
  logic [35:0] tot;
  logic [63:0] sq_v;
  logic [63:0] sq_res;
  logic [4:0]  sq_i;
  logic [47:0] dv_rem;
  logic [15:0] dv_q;
  logic [3:0]  dv_i;
  logic signed [55:0] de;
  logic signed [31:0] dq;
  logic [19:0] x;
  logic [30:0] t;
  logic [4:0]  ei;
  logic [60:0] eprod;
  logic        acc;
  logic signed [39:0] energy_sum;
  logic [31:0] accepted_total;

  logic signed [24:0] ma;
  logic signed [35:0] mb;
  logic signed [60:0] prod;

  logic signed [15:0] cmp [3];
  logic [47:0] jrow [3];
  logic [1:0]  mi;
  logic [1:0]  mj;
  logic signed [16:0] dk;
  logic [RW-1:0] r_up, r_dn;
  logic [CW-1:0] c_lf, c_rt;
  logic [AW-1:0] site;
  logic [AW-1:0] rd_addr;
  logic signed [60:0] rnd_p;
  logic signed [60:0] x_r;
  logic signed [55:0] de_r;
  logic [61:0] t_r;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic [48:0] dsh;
  logic        dv_take;
  logic [15:0] q_fin;
  logic signed [15:0] qs;
  logic [17:0] abs_p;
  logic signed [40:0] es;

  always_comb begin
    cmp[0]  = cur.comp_x;
    cmp[1]  = cur.comp_y;
    cmp[2]  = cur.comp_z;
    jrow[0] = cfg.j_x;
    jrow[1] = cfg.j_y;
    jrow[2] = cfg.j_z;
    mi      = 2'(m - 3'd1);
    mj      = 2'(m - 3'd4);
    dk      = 17'(nw[k]) - 17'(s[k]);
    r_up    = (r_i == '0) ? RW'(ROWS - 1) : r_i - 1'b1;
    r_dn    = (r_i == RW'(ROWS - 1)) ? '0 : r_i + 1'b1;
    c_lf    = (c_i == '0) ? CW'(COLS - 1) : c_i - 1'b1;
    c_rt    = (c_i == CW'(COLS - 1)) ? '0 : c_i + 1'b1;
    site    = addr_of(r_i, c_i);
    case (cnt)
      3'd0:    rd_addr = site;
      3'd1:    rd_addr = addr_of(r_up, c_i);
      3'd2:    rd_addr = addr_of(r_dn, c_i);
      3'd3:    rd_addr = addr_of(r_i, c_lf);
      default: rd_addr = addr_of(r_i, c_rt);
    endcase
    rnd_p   = prod + 61'sd32768;
    x_r     = (prod + 61'sd4194304) >>> 23;
    de_r    = (de + 56'sd8388608) >>> 24;
    t_r     = (62'(eprod) + 62'd536870912) >> 30;
    bitv    = 64'd1 << {sq_i, 1'b0};
    trial   = sq_res + bitv;
    dsh     = {16'd0, sq_res[31:0], 1'b0} << dv_i;
    dv_take = {1'b0, dv_rem} >= dsh;
    q_fin   = dv_q | (dv_take ? (16'd1 << dv_i) : 16'd0);
    qs      = (q_fin > 16'd16384) ? 16'sd16384 : $signed(q_fin);
    abs_p   = p[k][17] ? 18'(-p[k]) : 18'(p[k]);
    es      = 41'(energy_sum) + 41'(dq);
  end

  // shared multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_PROP: begin
        ma = 25'(cmp[k]);
        mb = 36'($signed({1'b0, cfg.step}));
      end
      S_SQR: begin
        ma = 25'(p[k]);
        mb = 36'(p[k]);
      end
      S_GSUM: begin
        if (m == 3'd0) begin
          ma = 25'(lane(cfg.field, k));
          mb = -36'sd16384;
        end else if (m < 3'd4) begin
          ma = 25'(lane(jrow[mi], k));
          mb = 36'(a_sum[mi]);
        end else begin
          ma = 25'(lane(jrow[k], mj));
          mb = 36'(b_sum[mj]);
        end
      end
      S_DSUM: begin
        ma = 25'(dk);
        mb = g[k];
      end
      S_SCALE: begin
        ma = $signed({1'b0, cfg.acc_scale});
        mb = 36'(dq);
      end
      default: ;
    endcase
  end

  assign req_pop = (state == S_IDLE) && req_valid;

  always_comb begin
    we    = 1'b0;
    waddr = site;
    wdata = {nw[2], nw[1], nw[0]};
    if (state == S_IDLE && req_valid && req.op == OP_LOAD) begin
      we    = 1'b1;
      waddr = addr_of(req.row[RW-1:0], req.col[CW-1:0]);
      wdata = {req.comp_z, req.comp_y, req.comp_x};
    end else if (state == S_COMMIT && acc) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    prod  <= ma * mb;
    eprod <= t * exp_tab(ei);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      energy_sum     <= '0;
      accepted_total <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            r_i <= req.row[RW-1:0];
            c_i <= req.col[CW-1:0];
            acc <= 1'b0;
            dq  <= '0;
            cnt <= '0;
            k   <= '0;
            ph  <= 1'b0;
            state <= (req.op == OP_LOAD) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          raddr <= rd_addr;
          cnt   <= cnt + 3'd1;
          case (cnt)
            3'd2: for (int i = 0; i < 3; i++) s[i] <= lane(rdata, 2'(i));
            3'd3: for (int i = 0; i < 3; i++) a_sum[i] <= 17'(lane(rdata, 2'(i)));
            3'd4: for (int i = 0; i < 3; i++) b_sum[i] <= 17'(lane(rdata, 2'(i)));
            3'd5: begin
              for (int i = 0; i < 3; i++) a_sum[i] <= a_sum[i] + 17'(lane(rdata, 2'(i)));
            end
            3'd6: begin
              for (int i = 0; i < 3; i++) b_sum[i] <= b_sum[i] + 17'(lane(rdata, 2'(i)));
              state <= S_PROP;
            end
            default: ;
          endcase
        end
        S_PROP: begin
          ph <= ~ph;
          if (ph) begin
            p[k] <= 18'(s[k]) + 18'(rnd_p >>> 16);
            if (k == 2'd2) begin
              k     <= '0;
              tot   <= '0;
              state <= S_SQR;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        S_SQR: begin
          ph <= ~ph;
          if (ph) begin
            tot <= tot + 36'(prod);
            if (k == 2'd2) begin
              k     <= '0;
              state <= S_CHECK;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        S_CHECK: begin
          if (tot == '0) begin
            state <= S_DONE;
          end else begin
            sq_v   <= {tot, 28'd0};
            sq_res <= '0;
            sq_i   <= 5'd31;
            state  <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sq_v >= trial) begin
            sq_v   <= sq_v - trial;
            sq_res <= (sq_res >> 1) + bitv;
          end else begin
            sq_res <= sq_res >> 1;
          end
          if (sq_i == 5'd0) state <= S_DIV;
          else sq_i <= sq_i - 5'd1;
        end
        S_DIV: begin
          if (!ph) begin
            dv_rem <= {1'b0, abs_p, 29'd0} + {16'd0, sq_res[31:0]};
            dv_q   <= '0;
            dv_i   <= 4'd15;
            ph     <= 1'b1;
          end else begin
            if (dv_take) dv_rem <= 48'({1'b0, dv_rem} - dsh);
            dv_q <= q_fin;
            if (dv_i == 4'd0) begin
              nw[k] <= p[k][17] ? -qs : qs;
              ph    <= 1'b0;
              if (k == 2'd2) begin
                k     <= '0;
                m     <= '0;
                for (int i = 0; i < 3; i++) g[i] <= '0;
                state <= S_GSUM;
              end else begin
                k <= k + 2'd1;
              end
            end else begin
              dv_i <= dv_i - 4'd1;
            end
          end
        end
        S_GSUM: begin
          ph <= ~ph;
          if (ph) begin
            g[k] <= g[k] + 36'(prod);
            if (m == 3'd6) begin
              m <= '0;
              if (k == 2'd2) begin
                k     <= '0;
                de    <= '0;
                state <= S_DSUM;
              end else begin
                k <= k + 2'd1;
              end
            end else begin
              m <= m + 3'd1;
            end
          end
        end
        S_DSUM: begin
          ph <= ~ph;
          if (ph) begin
            de <= de + 56'(prod);
            if (k == 2'd2) begin
              k     <= '0;
              state <= S_ROUND;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        S_ROUND: begin
          dq <= 32'(de_r);
          if (de_r <= 56'sd0) begin
            acc   <= 1'b1;
            state <= S_COMMIT;
          end else begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          ph <= ~ph;
          if (ph) begin
            if (x_r >= 61'sd1048576) begin
              t     <= '0;
              state <= S_JUDGE;
            end else begin
              x     <= 20'(x_r);
              t     <= 31'd1073741824;
              ei    <= '0;
              state <= S_EXP;
            end
          end
        end
        S_EXP: begin
          ph <= ~ph;
          if (ph) begin
            if (x[ei]) t <= 31'(t_r);
            if (ei == 5'd19) state <= S_JUDGE;
            else ei <= ei + 5'd1;
          end
        end
        S_JUDGE: begin
          acc   <= {1'b0, cur.uniform_draw, 14'd0} <= t;
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (acc) begin
            if (es > 41'sd549755813887) energy_sum <= 40'sd549755813887;
            else if (es < -41'sd549755813888) energy_sum <= -40'sd549755813888;
            else energy_sum <= 40'(es);
            accepted_total <= accepted_total + 32'd1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            res.accepted     <= acc;
            res.energy_delta <= dq;
            res.total_energy <= energy_sum;
            res.accept_count <= accepted_total;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- dv/tb_heisenberg_metropolis_site_update.sv -----
`timescale 1ns / 100ps

module tb_heisenberg_metropolis_site_update;
  import hmsu_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 225;

  typedef struct {
    logic               op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic [15:0]        u;
  } site_req_t;

  class metropolis_scoreboard;
    static const longint unsigned EXP_NEG_POW2[20] = '{
      1073725440, 1073709056, 1073676290, 1073610760, 1073479712,
      1073217664, 1072693760, 1071646719, 1069555701, 1065385899,
      1057095000, 1040706261, 1008687096, 947573834, 836230973,
      651257337, 395007542, 145315154, 19666268, 360200};

    logic [47:0] spins[256];
    logic [47:0] j_rows[3];
    logic [47:0] field_h;
    logic [15:0] step_q;
    logic [23:0] acc_q;
    longint      energy_run;
    logic [31:0] accept_run;
    res_t        pending[$];
    int          mismatches;

    function new();
      j_rows = '{48'd0, 48'd0, 48'd0};
      field_h = 48'd0;
      step_q = 16'd32768;
      acc_q = 24'd83886;
      energy_run = 0;
      accept_run = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        REG_COUPLING_X: j_rows[0] = v[47:0];
        REG_COUPLING_Y: j_rows[1] = v[47:0];
        REG_COUPLING_Z: j_rows[2] = v[47:0];
        REG_FIELD:      field_h = v[47:0];
        REG_STEP:       step_q = v[15:0];
        REG_ACC_SCALE:  acc_q = v[23:0];
        default: ;
      endcase
    endfunction

    function longint lanev(logic [47:0] p, int i);
      return longint'($signed(p[16*i +: 16]));
    endfunction

    function longint rnd_shr(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint bond(longint a[3], longint b[3]);
      longint sum;
      sum = 0;
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          sum += lanev(j_rows[i], k) * a[i] * b[k];
      return sum;
    endfunction

    function longint site_energy(longint v[3], longint up[3], longint dn[3],
                                 longint lf[3], longint rt[3]);
      longint e;
      e = 0;
      for (int i = 0; i < 3; i++) e -= lanev(field_h, i) * v[i] * 16384;
      return e + bond(up, v) + bond(v, dn) + bond(lf, v) + bond(v, rt);
    endfunction

    function void note_request(site_req_t q);
      int r, c, site;
      longint s[3], p[3], nw[3], up[3], dn[3], lf[3], rt[3], cmp[3];
      longint de, dq, x, qv;
      longint unsigned tot, n, a, t;
      bit acc;
      res_t e;
      r = q.row;
      c = q.col;
      site = r * 16 + c;
      cmp = '{longint'(q.cx), longint'(q.cy), longint'(q.cz)};
      acc = 0;
      dq = 0;
      if (q.op == OP_LOAD) begin
        spins[site] = {q.cz, q.cy, q.cx};
      end else begin
        tot = 0;
        for (int i = 0; i < 3; i++) begin
          s[i] = lanev(spins[site], i);
          p[i] = s[i] + rnd_shr(cmp[i] * longint'(step_q), 16);
          tot += longint'(p[i] * p[i]);
        end
        if (tot != 0) begin
          n = int_sqrt(tot << 28);
          for (int i = 0; i < 3; i++) begin
            a = longint'(p[i] < 0 ? -p[i] : p[i]) << 28;
            qv = longint'((2 * a + n) / (2 * n));
            if (qv > 16384) qv = 16384;
            nw[i] = p[i] < 0 ? -qv : qv;
          end
          for (int i = 0; i < 3; i++) begin
            up[i] = lanev(spins[((r + 15) % 16) * 16 + c], i);
            dn[i] = lanev(spins[((r + 1) % 16) * 16 + c], i);
            lf[i] = lanev(spins[r * 16 + (c + 15) % 16], i);
            rt[i] = lanev(spins[r * 16 + (c + 1) % 16], i);
          end
          de = site_energy(nw, up, dn, lf, rt) - site_energy(s, up, dn, lf, rt);
          dq = rnd_shr(de, 24);
          if (dq > 64'sd2147483647) dq = 64'sd2147483647;
          if (dq < -64'sd2147483648) dq = -64'sd2147483648;
          if (dq <= 0) begin
            acc = 1;
          end else begin
            t = 64'h1 << 30;
            x = rnd_shr(dq * longint'(acc_q), 23);
            if (x >= (longint'(1) << 20)) begin
              t = 0;
            end else begin
              for (int i = 0; i < 20; i++)
                if (x[i]) t = (t * EXP_NEG_POW2[i] + (64'h1 << 29)) >> 30;
            end
            acc = (longint'(q.u) << 14) <= t;
          end
          if (acc) begin
            spins[site] = {nw[2][15:0], nw[1][15:0], nw[0][15:0]};
            energy_run += dq;
            if (energy_run > (longint'(1) << 39) - 1) energy_run = (longint'(1) << 39) - 1;
            if (energy_run < -(longint'(1) << 39)) energy_run = -(longint'(1) << 39);
            accept_run += 1;
          end
        end
      end
      e.accepted = acc;
      e.energy_delta = dq[31:0];
      e.total_energy = energy_run[39:0];
      e.accept_count = accept_run;
      pending.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.accepted !== e.accepted || got.energy_delta !== e.energy_delta ||
          got.total_energy !== e.total_energy || got.accept_count !== e.accept_count) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [5:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;
  logic               in_valid, in_ready;
  logic               op;
  logic [3:0]         row, col;
  logic signed [15:0] comp_x, comp_y, comp_z;
  logic [15:0]        uniform_draw;
  logic               out_valid, out_ready;
  logic               accepted;
  logic signed [31:0] energy_delta;
  logic signed [39:0] total_energy;
  logic [31:0]        accept_count;

  metropolis_scoreboard sb;
  int  tx_idle_pct, rx_idle_pct;
  int  quiet_cycles = 0;
  bit  loaded[256];

  heisenberg_metropolis_site_update dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request('{op, row, col, comp_x, comp_y, comp_z,
                                                 uniform_draw});
      if (out_valid && out_ready) sb.check_result('{accepted, energy_delta, total_energy,
                                                   accept_count});
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_heisenberg_metropolis_site_update failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_req(site_req_t q);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    op <= q.op;
    row <= q.row;
    col <= q.col;
    comp_x <= q.cx;
    comp_y <= q.cy;
    comp_z <= q.cz;
    uniform_draw <= q.u;
    if (q.op == OP_LOAD) loaded[q.row * 16 + q.col] = 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_site(int r, int c, int x, int y, int z);
    send_req('{OP_LOAD, 4'(r), 4'(c), 16'(x), 16'(y), 16'(z), 16'd0});
  endtask

  task automatic update_site(int r, int c, int x, int y, int z, int u);
    send_req('{OP_UPDATE, 4'(r), 4'(c), 16'(x), 16'(y), 16'(z), 16'(u)});
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(7))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic [47:0] rand_packed(int phase);
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    if (phase == 1)
      for (int i = 0; i < 3; i++) v[16*i +: 16] = 16'($signed($urandom_range(4096)) - 2048);
    return v;
  endfunction

  task automatic random_item();
    site_req_t q;
    int r, c, nb[5];
    q.row = 4'($urandom_range(15));
    q.col = 4'($urandom_range(15));
    q.cx = rand_comp();
    q.cy = rand_comp();
    q.cz = rand_comp();
    q.u = 16'($urandom);
    q.op = ($urandom_range(99) < 70) ? OP_UPDATE : OP_LOAD;
    r = q.row;
    c = q.col;
    nb = '{r * 16 + c, ((r + 15) % 16) * 16 + c, ((r + 1) % 16) * 16 + c,
           r * 16 + (c + 15) % 16, r * 16 + (c + 1) % 16};
    if (q.op == OP_UPDATE) begin
      foreach (nb[i]) begin
        if (!loaded[nb[i]] && q.op == OP_UPDATE) begin
          q.op = OP_LOAD;
          q.row = 4'(nb[i] / 16);
          q.col = 4'(nb[i] % 16);
        end
      end
    end
    send_req(q);
  endtask

  initial begin
    logic [63:0] regs[6];
    sb = new();
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    in_valid = 0;
    op = OP_LOAD;
    row = 0;
    col = 0;
    comp_x = 0;
    comp_y = 0;
    comp_z = 0;
    uniform_draw = 0;
    tx_idle_pct = 18;
    rx_idle_pct = 51;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int phase = 0; phase < 6; phase++) begin
      tx_idle_pct = (phase < 2) ? 18 : (phase < 4) ? 51 : 0;
      rx_idle_pct = (phase < 2) ? 51 : (phase < 4) ? 18 : 0;
      if (phase > 0) begin
        drain();
        for (int i = 0; i < 4; i++) regs[i] = 64'(rand_packed(phase));
        regs[4] = 64'($urandom_range(65535));
        regs[5] = (phase == 1) ? 64'($urandom_range(400000)) :
                                 64'($urandom_range(24'hFFFFFF));
        if (phase == 2) begin
          regs = '{64'h7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF,
                   64'h8000_8000_8000, 64'hFFFF, 64'hFFFFFF};
        end else if (phase == 3) begin
          regs[4] = 0;
          regs[5] = 0;
        end else if (phase == 5) begin
          regs[0] = 64'h8000_8000_8000;
          regs[3] = 64'h7FFF_7FFF_7FFF;
        end
        write_reg(REG_COUPLING_X, regs[0]);
        write_reg(REG_COUPLING_Y, regs[1]);
        write_reg(REG_COUPLING_Z, regs[2]);
        write_reg(REG_FIELD, regs[3]);
        write_reg(REG_STEP, regs[4]);
        write_reg(REG_ACC_SCALE, regs[5]);
      end
      if (phase == 1) begin
        load_site(15, 0, 16384, 0, 0);
        load_site(1, 0, -16384, 0, 0);
        load_site(0, 15, 0, 16384, 0);
        load_site(0, 1, 0, -16384, 16384);
        load_site(0, 0, 8192, 0, 0);
        // proposal opposes the spin along x
        update_site(0, 0, -16384, 0, 0, 0);
        update_site(0, 0, 16384, 16384, 16384, 65535);
        update_site(0, 0, -16384, -16384, -16384, 0);
        update_site(0, 0, 0, 0, 0, 65535);
        load_site(0, 0, 0, 0, 0);
        // zero spin and zero proposal
        update_site(0, 0, 0, 0, 0, 0);
        load_site(14, 15, -16384, -16384, -16384);
        load_site(15, 14, 16384, 16384, 16384);
        load_site(15, 15, 0, 0, -16384);
        update_site(15, 15, 16384, -16384, 1, 32768);
        update_site(15, 15, -1, 16384, 0, 65535);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_heisenberg_metropolis_site_update passed");
    end else begin
      $display("tb_heisenberg_metropolis_site_update failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/hmsu_pkg.sv
src/hmsu_front.sv
src/hmsu_back.sv
src/heisenberg_metropolis_site_update.sv
dv/tb_heisenberg_metropolis_site_update.sv
